// ===== hdl/env_sensor_compensation_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ENV_SENSOR_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define ESC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("esc check failed");

// Clocked assertion that also holds during reset.
`define ESC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) else $error("esc check failed");

`endif

// ===== hdl/esc_pkg.sv =====
// Types, codes and the compensation microprogram.
package esc_pkg;

   localparam int DATA_W   = 64;
   localparam int PROG_LEN = 78;
   localparam int PC_W     = $clog2(PROG_LEN);

   localparam logic [23:0] SKIP_CODE_24 = 24'h800000;
   localparam logic [15:0] SKIP_CODE_16 = 16'h8000;
   localparam logic [31:0] HUM_LIMIT    = 32'd419430400;

   typedef enum logic [2:0] {
      CSR_TEMP      = 3'd0,
      CSR_PRESS_LOW = 3'd1,
      CSR_PRESS_HI  = 3'd2,
      CSR_PRESS_P9  = 3'd3,
      CSR_HUM       = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      GRP_T = 2'd0,
      GRP_P = 2'd1,
      GRP_H = 2'd2
   } grp_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_ADD, OP_SUB, OP_SHL, OP_ASR, OP_MUL, OP_DIV,
      OP_FINE, OP_TOUT, OP_PSAT, OP_HSAT, OP_CHKZ
   } op_type;

   typedef enum logic [5:0] {
      SRC_R0, SRC_R1, SRC_R2, SRC_R3,
      SRC_T1, SRC_T2, SRC_T3,
      SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
      SRC_H1, SRC_H2, SRC_H3, SRC_H4, SRC_H5, SRC_H6,
      SRC_ADC_T, SRC_ADC_P, SRC_ADC_H, SRC_FINE,
      SRC_C1, SRC_C5, SRC_C128, SRC_C128000, SRC_C1048576, SRC_C3125,
      SRC_C76800, SRC_C16384, SRC_C32768, SRC_C2097152, SRC_C8192
   } src_type;

   typedef struct packed {
      grp_type     grp;
      op_type      op;
      logic [1:0]  dst;
      src_type     a;
      src_type     b;
      logic [5:0]  sh;
      logic        wrap;
   } cmd_type;

   typedef struct packed {
      logic    start;
      logic    issue;
      cmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic tskip;
      logic pskip;
      logic hskip;
      logic unit_done;
   } stat_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_RUN, ST_WAIT, ST_DONE
   } state_type;

   function automatic cmd_type mk(grp_type g, op_type o, logic [1:0] d,
                                  src_type a, src_type b, logic [5:0] sh);
      cmd_type c;
      c.grp  = g;
      c.op   = o;
      c.dst  = d;
      c.a    = a;
      c.b    = b;
      c.sh   = sh;
      c.wrap = (g == GRP_H);
      return c;
   endfunction

   function automatic cmd_type prog(logic [PC_W-1:0] pc);
      cmd_type c;
      c = mk(GRP_T, OP_NOP, 2'd0, SRC_R0, SRC_R0, 6'd0);
      unique case (pc)
         // temperature
         7'd0:  c = mk(GRP_T, OP_ASR,  2'd0, SRC_ADC_T, SRC_R0, 6'd3);
         7'd1:  c = mk(GRP_T, OP_SHL,  2'd1, SRC_T1, SRC_R0, 6'd1);
         7'd2:  c = mk(GRP_T, OP_SUB,  2'd0, SRC_R0, SRC_R1, 6'd0);
         7'd3:  c = mk(GRP_T, OP_MUL,  2'd0, SRC_R0, SRC_T2, 6'd0);
         7'd4:  c = mk(GRP_T, OP_ASR,  2'd0, SRC_R0, SRC_R0, 6'd11);
         7'd5:  c = mk(GRP_T, OP_ASR,  2'd1, SRC_ADC_T, SRC_R0, 6'd4);
         7'd6:  c = mk(GRP_T, OP_SUB,  2'd1, SRC_R1, SRC_T1, 6'd0);
         7'd7:  c = mk(GRP_T, OP_MUL,  2'd1, SRC_R1, SRC_R1, 6'd0);
         7'd8:  c = mk(GRP_T, OP_ASR,  2'd1, SRC_R1, SRC_R0, 6'd12);
         7'd9:  c = mk(GRP_T, OP_MUL,  2'd1, SRC_R1, SRC_T3, 6'd0);
         7'd10: c = mk(GRP_T, OP_ASR,  2'd1, SRC_R1, SRC_R0, 6'd14);
         7'd11: c = mk(GRP_T, OP_ADD,  2'd0, SRC_R0, SRC_R1, 6'd0);
         7'd12: c = mk(GRP_T, OP_FINE, 2'd0, SRC_R0, SRC_R0, 6'd0);
         7'd13: c = mk(GRP_T, OP_MUL,  2'd0, SRC_FINE, SRC_C5, 6'd0);
         7'd14: c = mk(GRP_T, OP_ADD,  2'd0, SRC_R0, SRC_C128, 6'd0);
         7'd15: c = mk(GRP_T, OP_TOUT, 2'd0, SRC_R0, SRC_R0, 6'd0);
         // pressure
         7'd16: c = mk(GRP_P, OP_SUB,  2'd0, SRC_FINE, SRC_C128000, 6'd0);
         7'd17: c = mk(GRP_P, OP_MUL,  2'd1, SRC_R0, SRC_R0, 6'd0);
         7'd18: c = mk(GRP_P, OP_MUL,  2'd2, SRC_R1, SRC_P6, 6'd0);
         7'd19: c = mk(GRP_P, OP_MUL,  2'd3, SRC_R0, SRC_P5, 6'd0);
         7'd20: c = mk(GRP_P, OP_SHL,  2'd3, SRC_R3, SRC_R0, 6'd17);
         7'd21: c = mk(GRP_P, OP_ADD,  2'd2, SRC_R2, SRC_R3, 6'd0);
         7'd22: c = mk(GRP_P, OP_SHL,  2'd3, SRC_P4, SRC_R0, 6'd35);
         7'd23: c = mk(GRP_P, OP_ADD,  2'd2, SRC_R2, SRC_R3, 6'd0);
         7'd24: c = mk(GRP_P, OP_MUL,  2'd1, SRC_R1, SRC_P3, 6'd0);
         7'd25: c = mk(GRP_P, OP_ASR,  2'd1, SRC_R1, SRC_R0, 6'd8);
         7'd26: c = mk(GRP_P, OP_MUL,  2'd3, SRC_R0, SRC_P2, 6'd0);
         7'd27: c = mk(GRP_P, OP_SHL,  2'd3, SRC_R3, SRC_R0, 6'd12);
         7'd28: c = mk(GRP_P, OP_ADD,  2'd1, SRC_R1, SRC_R3, 6'd0);
         7'd29: c = mk(GRP_P, OP_SHL,  2'd3, SRC_C1, SRC_R0, 6'd47);
         7'd30: c = mk(GRP_P, OP_ADD,  2'd1, SRC_R1, SRC_R3, 6'd0);
         7'd31: c = mk(GRP_P, OP_MUL,  2'd1, SRC_R1, SRC_P1, 6'd0);
         7'd32: c = mk(GRP_P, OP_ASR,  2'd1, SRC_R1, SRC_R0, 6'd33);
         7'd33: c = mk(GRP_P, OP_CHKZ, 2'd0, SRC_R1, SRC_R0, 6'd0);
         7'd34: c = mk(GRP_P, OP_SUB,  2'd0, SRC_C1048576, SRC_ADC_P, 6'd0);
         7'd35: c = mk(GRP_P, OP_SHL,  2'd0, SRC_R0, SRC_R0, 6'd31);
         7'd36: c = mk(GRP_P, OP_SUB,  2'd0, SRC_R0, SRC_R2, 6'd0);
         7'd37: c = mk(GRP_P, OP_MUL,  2'd0, SRC_R0, SRC_C3125, 6'd0);
         7'd38: c = mk(GRP_P, OP_DIV,  2'd0, SRC_R0, SRC_R1, 6'd0);
         7'd39: c = mk(GRP_P, OP_ASR,  2'd1, SRC_R0, SRC_R0, 6'd13);
         7'd40: c = mk(GRP_P, OP_MUL,  2'd2, SRC_P9, SRC_R1, 6'd0);
         7'd41: c = mk(GRP_P, OP_MUL,  2'd2, SRC_R2, SRC_R1, 6'd0);
         7'd42: c = mk(GRP_P, OP_ASR,  2'd2, SRC_R2, SRC_R0, 6'd25);
         7'd43: c = mk(GRP_P, OP_MUL,  2'd3, SRC_P8, SRC_R0, 6'd0);
         7'd44: c = mk(GRP_P, OP_ASR,  2'd3, SRC_R3, SRC_R0, 6'd19);
         7'd45: c = mk(GRP_P, OP_ADD,  2'd0, SRC_R0, SRC_R2, 6'd0);
         7'd46: c = mk(GRP_P, OP_ADD,  2'd0, SRC_R0, SRC_R3, 6'd0);
         7'd47: c = mk(GRP_P, OP_ASR,  2'd0, SRC_R0, SRC_R0, 6'd8);
         7'd48: c = mk(GRP_P, OP_SHL,  2'd1, SRC_P7, SRC_R0, 6'd4);
         7'd49: c = mk(GRP_P, OP_ADD,  2'd0, SRC_R0, SRC_R1, 6'd0);
         7'd50: c = mk(GRP_P, OP_PSAT, 2'd0, SRC_R0, SRC_R0, 6'd0);
         // humidity, 32-bit wrapping
         7'd51: c = mk(GRP_H, OP_SUB,  2'd0, SRC_FINE, SRC_C76800, 6'd0);
         7'd52: c = mk(GRP_H, OP_SHL,  2'd1, SRC_ADC_H, SRC_R0, 6'd14);
         7'd53: c = mk(GRP_H, OP_SHL,  2'd2, SRC_H4, SRC_R0, 6'd20);
         7'd54: c = mk(GRP_H, OP_SUB,  2'd1, SRC_R1, SRC_R2, 6'd0);
         7'd55: c = mk(GRP_H, OP_MUL,  2'd2, SRC_H5, SRC_R0, 6'd0);
         7'd56: c = mk(GRP_H, OP_SUB,  2'd1, SRC_R1, SRC_R2, 6'd0);
         7'd57: c = mk(GRP_H, OP_ADD,  2'd1, SRC_R1, SRC_C16384, 6'd0);
         7'd58: c = mk(GRP_H, OP_ASR,  2'd1, SRC_R1, SRC_R0, 6'd15);
         7'd59: c = mk(GRP_H, OP_MUL,  2'd2, SRC_R0, SRC_H6, 6'd0);
         7'd60: c = mk(GRP_H, OP_ASR,  2'd2, SRC_R2, SRC_R0, 6'd10);
         7'd61: c = mk(GRP_H, OP_MUL,  2'd3, SRC_R0, SRC_H3, 6'd0);
         7'd62: c = mk(GRP_H, OP_ASR,  2'd3, SRC_R3, SRC_R0, 6'd11);
         7'd63: c = mk(GRP_H, OP_ADD,  2'd3, SRC_R3, SRC_C32768, 6'd0);
         7'd64: c = mk(GRP_H, OP_MUL,  2'd2, SRC_R2, SRC_R3, 6'd0);
         7'd65: c = mk(GRP_H, OP_ASR,  2'd2, SRC_R2, SRC_R0, 6'd10);
         7'd66: c = mk(GRP_H, OP_ADD,  2'd2, SRC_R2, SRC_C2097152, 6'd0);
         7'd67: c = mk(GRP_H, OP_MUL,  2'd2, SRC_R2, SRC_H2, 6'd0);
         7'd68: c = mk(GRP_H, OP_ADD,  2'd2, SRC_R2, SRC_C8192, 6'd0);
         7'd69: c = mk(GRP_H, OP_ASR,  2'd2, SRC_R2, SRC_R0, 6'd14);
         7'd70: c = mk(GRP_H, OP_MUL,  2'd0, SRC_R1, SRC_R2, 6'd0);
         7'd71: c = mk(GRP_H, OP_ASR,  2'd1, SRC_R0, SRC_R0, 6'd15);
         7'd72: c = mk(GRP_H, OP_MUL,  2'd1, SRC_R1, SRC_R1, 6'd0);
         7'd73: c = mk(GRP_H, OP_ASR,  2'd1, SRC_R1, SRC_R0, 6'd7);
         7'd74: c = mk(GRP_H, OP_MUL,  2'd1, SRC_R1, SRC_H1, 6'd0);
         7'd75: c = mk(GRP_H, OP_ASR,  2'd1, SRC_R1, SRC_R0, 6'd4);
         7'd76: c = mk(GRP_H, OP_SUB,  2'd0, SRC_R0, SRC_R1, 6'd0);
         7'd77: c = mk(GRP_H, OP_HSAT, 2'd0, SRC_R0, SRC_R0, 6'd0);
         default: c = mk(GRP_T, OP_NOP, 2'd0, SRC_R0, SRC_R0, 6'd0);
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/esc_if.sv =====
// Valid/ready channel interfaces for raw samples and compensated results.
interface esc_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] raw_temp;
   logic [23:0] raw_press;
   logic [15:0] raw_hum;
   modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
   modport sink   (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

interface esc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] temperature;
   logic [31:0]        pressure;
   logic [16:0]        humidity;
   logic               temp_skipped;
   logic               press_skipped;
   logic               hum_skipped;
   modport source (output valid, temperature, pressure, humidity,
                   temp_skipped, press_skipped, hum_skipped, input ready);
   modport sink   (input valid, temperature, pressure, humidity,
                   temp_skipped, press_skipped, hum_skipped, output ready);
endinterface

// ===== hdl/esc_mul.sv =====
// 64x64 low-half multiplier: one 32x32 multiplier, three partial products.
module esc_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] result,
   output logic        done
);
   logic [63:0] a_ff, b_ff, acc_ff;
   logic [1:0]  step_ff;
   logic        busy_ff, done_ff;
   logic [31:0] ma, mb;
   logic [63:0] m;

   always_comb begin
      case (step_ff)
         2'd0:    begin ma = a_ff[31:0];  mb = b_ff[31:0];  end
         2'd1:    begin ma = a_ff[31:0];  mb = b_ff[63:32]; end
         default: begin ma = a_ff[63:32]; mb = b_ff[31:0];  end
      endcase
      m = ma * mb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end else if (busy_ff) begin
         if (step_ff == 2'd0) acc_ff <= m;
         else acc_ff[63:32] <= acc_ff[63:32] + m[31:0];
      end
   end

   assign result = acc_ff;
   assign done   = done_ff;
endmodule

// ===== hdl/esc_div.sv =====
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating.
module esc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [63:0] result,
   output logic        done
);
   logic [63:0] rem_ff, quo_ff, den_ff, res_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff, busy_ff, fix_ff, done_ff;
   logic [63:0] trial;
   logic        fits;

   assign trial = {rem_ff[62:0], quo_ff[63]};
   assign fits  = (trial >= den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               fix_ff  <= 1'b1;
            end
         end else if (fix_ff) begin
            fix_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 64'd0;
         quo_ff <= num[63] ? (~num + 64'd1) : num;
         den_ff <= den[63] ? (~den + 64'd1) : den;
         neg_ff <= num[63] ^ den[63];
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - den_ff) : trial;
         quo_ff <= {quo_ff[62:0], fits};
      end else if (fix_ff) begin
         res_ff <= neg_ff ? (~quo_ff + 64'd1) : quo_ff;
      end
   end

   assign result = res_ff;
   assign done   = done_ff;
endmodule

// ===== hdl/esc_datapath.sv =====
// Datapath: calibration registers, working registers, ALU, shared mul and div.
module esc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  esc_pkg::ctl_type     ctl,
   output esc_pkg::stat_type    stat,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic [23:0]          raw_temp,
   input  logic [23:0]          raw_press,
   input  logic [15:0]          raw_hum,
   output logic signed [15:0]   temperature,
   output logic [31:0]          pressure,
   output logic [16:0]          humidity,
   output logic                 temp_skipped,
   output logic                 press_skipped,
   output logic                 hum_skipped
);
   logic [47:0] tc_ff;
   logic [63:0] pl_ff, ph_ff, hc_ff;
   logic [15:0] p9_ff;
   logic [23:0] rt_ff, rp_ff;
   logic [15:0] rh_ff;
   logic [63:0] r0_ff, r1_ff, r2_ff, r3_ff;
   logic [31:0] fine_ff;
   logic [15:0] temp_ff;
   logic [31:0] press_ff;
   logic [16:0] hum_ff;
   logic        tskip_ff, pskip_ff, hskip_ff;
   logic [1:0]  pend_dst_ff;
   logic        pend_wrap_ff;

   logic [63:0] a_val, b_val, alu_val, wr_raw, wr_val, mul_res, div_res, q8;
   logic        mul_done, div_done, wr_en, wr_wrap;
   logic [1:0]  wr_dst;
   logic [31:0] fine_in, press_in, hv;
   logic [15:0] temp_in;
   logic [16:0] hum_in;
   esc_pkg::op_type op;

   function automatic logic [63:0] pick(esc_pkg::src_type s);
      logic [63:0] v;
      case (s)
         esc_pkg::SRC_R0:       v = r0_ff;
         esc_pkg::SRC_R1:       v = r1_ff;
         esc_pkg::SRC_R2:       v = r2_ff;
         esc_pkg::SRC_R3:       v = r3_ff;
         esc_pkg::SRC_T1:       v = {48'd0, tc_ff[15:0]};
         esc_pkg::SRC_T2:       v = {{48{tc_ff[31]}}, tc_ff[31:16]};
         esc_pkg::SRC_T3:       v = {{48{tc_ff[47]}}, tc_ff[47:32]};
         esc_pkg::SRC_P1:       v = {48'd0, pl_ff[15:0]};
         esc_pkg::SRC_P2:       v = {{48{pl_ff[31]}}, pl_ff[31:16]};
         esc_pkg::SRC_P3:       v = {{48{pl_ff[47]}}, pl_ff[47:32]};
         esc_pkg::SRC_P4:       v = {{48{pl_ff[63]}}, pl_ff[63:48]};
         esc_pkg::SRC_P5:       v = {{48{ph_ff[15]}}, ph_ff[15:0]};
         esc_pkg::SRC_P6:       v = {{48{ph_ff[31]}}, ph_ff[31:16]};
         esc_pkg::SRC_P7:       v = {{48{ph_ff[47]}}, ph_ff[47:32]};
         esc_pkg::SRC_P8:       v = {{48{ph_ff[63]}}, ph_ff[63:48]};
         esc_pkg::SRC_P9:       v = {{48{p9_ff[15]}}, p9_ff};
         esc_pkg::SRC_H1:       v = {56'd0, hc_ff[7:0]};
         esc_pkg::SRC_H2:       v = {{48{hc_ff[23]}}, hc_ff[23:8]};
         esc_pkg::SRC_H3:       v = {56'd0, hc_ff[31:24]};
         esc_pkg::SRC_H4:       v = {52'd0, hc_ff[43:32]};
         esc_pkg::SRC_H5:       v = {52'd0, hc_ff[55:44]};
         esc_pkg::SRC_H6:       v = {{56{hc_ff[63]}}, hc_ff[63:56]};
         esc_pkg::SRC_ADC_T:    v = {44'd0, rt_ff[23:4]};
         esc_pkg::SRC_ADC_P:    v = {44'd0, rp_ff[23:4]};
         esc_pkg::SRC_ADC_H:    v = {48'd0, rh_ff};
         esc_pkg::SRC_FINE:     v = {{32{fine_ff[31]}}, fine_ff};
         esc_pkg::SRC_C1:       v = 64'd1;
         esc_pkg::SRC_C5:       v = 64'd5;
         esc_pkg::SRC_C128:     v = 64'd128;
         esc_pkg::SRC_C128000:  v = 64'd128000;
         esc_pkg::SRC_C1048576: v = 64'd1048576;
         esc_pkg::SRC_C3125:    v = 64'd3125;
         esc_pkg::SRC_C76800:   v = 64'd76800;
         esc_pkg::SRC_C16384:   v = 64'd16384;
         esc_pkg::SRC_C32768:   v = 64'd32768;
         esc_pkg::SRC_C2097152: v = 64'd2097152;
         esc_pkg::SRC_C8192:    v = 64'd8192;
         default:               v = 64'd0;
      endcase
      return v;
   endfunction

   esc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.issue && (ctl.cmd.op == esc_pkg::OP_MUL)),
      .a      (a_val),
      .b      (b_val),
      .result (mul_res),
      .done   (mul_done)
   );

   esc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.issue && (ctl.cmd.op == esc_pkg::OP_DIV)),
      .num    (a_val),
      .den    (b_val),
      .result (div_res),
      .done   (div_done)
   );

   always_comb begin
      op    = ctl.cmd.op;
      a_val = pick(ctl.cmd.a);
      b_val = pick(ctl.cmd.b);
      case (op)
         esc_pkg::OP_ADD: alu_val = a_val + b_val;
         esc_pkg::OP_SUB: alu_val = a_val - b_val;
         esc_pkg::OP_SHL: alu_val = a_val << ctl.cmd.sh;
         esc_pkg::OP_ASR: alu_val = $unsigned($signed(a_val) >>> ctl.cmd.sh);
         default:         alu_val = a_val;
      endcase

      wr_en   = 1'b0;
      wr_dst  = ctl.cmd.dst;
      wr_wrap = ctl.cmd.wrap;
      wr_raw  = alu_val;
      if (mul_done || div_done) begin
         wr_en   = 1'b1;
         wr_dst  = pend_dst_ff;
         wr_wrap = pend_wrap_ff;
         wr_raw  = mul_done ? mul_res : div_res;
      end else if (ctl.issue) begin
         case (op) inside
            esc_pkg::OP_ADD, esc_pkg::OP_SUB, esc_pkg::OP_SHL, esc_pkg::OP_ASR:
               wr_en = 1'b1;
            default: wr_en = 1'b0;
         endcase
      end
      wr_val = wr_wrap ? {{32{wr_raw[31]}}, wr_raw[31:0]} : wr_raw;

      // saturating result stages
      if ((&a_val[63:31]) || !(|a_val[63:31])) fine_in = a_val[31:0];
      else fine_in = a_val[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;

      q8 = $unsigned($signed(a_val) >>> 8);
      if ((&q8[63:15]) || !(|q8[63:15])) temp_in = q8[15:0];
      else temp_in = q8[63] ? 16'h8000 : 16'h7FFF;

      if (a_val[63]) press_in = 32'd0;
      else if (|a_val[62:32]) press_in = 32'hFFFF_FFFF;
      else press_in = a_val[31:0];

      hv = a_val[31:0];
      if (hv[31]) hv = 32'd0;
      else if (hv > esc_pkg::HUM_LIMIT) hv = esc_pkg::HUM_LIMIT;
      hum_in = hv[28:12];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff    <= '0;
         pl_ff    <= '0;
         ph_ff    <= '0;
         p9_ff    <= '0;
         hc_ff    <= '0;
         fine_ff  <= '0;
         tskip_ff <= 1'b0;
         pskip_ff <= 1'b0;
         hskip_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               esc_pkg::CSR_TEMP:      tc_ff <= csr_wdata[47:0];
               esc_pkg::CSR_PRESS_LOW: pl_ff <= csr_wdata;
               esc_pkg::CSR_PRESS_HI:  ph_ff <= csr_wdata;
               esc_pkg::CSR_PRESS_P9:  p9_ff <= csr_wdata[15:0];
               esc_pkg::CSR_HUM:       hc_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (ctl.start) begin
            tskip_ff <= (raw_temp == esc_pkg::SKIP_CODE_24);
            pskip_ff <= (raw_press == esc_pkg::SKIP_CODE_24);
            hskip_ff <= (raw_hum == esc_pkg::SKIP_CODE_16);
         end else if (ctl.issue && (op == esc_pkg::OP_CHKZ) && (a_val == 64'd0)) begin
            pskip_ff <= 1'b1;
         end
         if (ctl.issue && (op == esc_pkg::OP_FINE)) fine_ff <= fine_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rt_ff    <= raw_temp;
         rp_ff    <= raw_press;
         rh_ff    <= raw_hum;
         temp_ff  <= 16'd0;
         press_ff <= 32'd0;
         hum_ff   <= 17'd0;
      end else if (ctl.issue) begin
         case (op)
            esc_pkg::OP_TOUT: temp_ff  <= temp_in;
            esc_pkg::OP_PSAT: press_ff <= press_in;
            esc_pkg::OP_HSAT: hum_ff   <= hum_in;
            default: ;
         endcase
      end
      if (ctl.issue) begin
         pend_dst_ff  <= ctl.cmd.dst;
         pend_wrap_ff <= ctl.cmd.wrap;
      end
      if (wr_en) begin
         case (wr_dst)
            2'd0:    r0_ff <= wr_val;
            2'd1:    r1_ff <= wr_val;
            2'd2:    r2_ff <= wr_val;
            default: r3_ff <= wr_val;
         endcase
      end
   end

   assign stat.tskip     = tskip_ff;
   assign stat.pskip     = pskip_ff;
   assign stat.hskip     = hskip_ff;
   assign stat.unit_done = mul_done || div_done;

   assign temperature   = $signed(temp_ff);
   assign pressure      = press_ff;
   assign humidity      = hum_ff;
   assign temp_skipped  = tskip_ff;
   assign press_skipped = pskip_ff;
   assign hum_skipped   = hskip_ff;
endmodule

// ===== hdl/esc_ctrl.sv =====
// Controller: sequences the microprogram and runs the channel handshakes.
module esc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  esc_pkg::stat_type stat,
   output esc_pkg::ctl_type  ctl
);
   esc_pkg::state_type state_ff, state_in;
   logic [esc_pkg::PC_W-1:0] pc_ff, pc_in;
   esc_pkg::cmd_type cmd;
   logic skip, multi, last;

   always_comb begin
      cmd = esc_pkg::prog(pc_ff);
      case (cmd.grp)
         esc_pkg::GRP_T: skip = stat.tskip;
         esc_pkg::GRP_P: skip = stat.pskip;
         default:        skip = stat.hskip;
      endcase
      multi = (cmd.op == esc_pkg::OP_MUL) || (cmd.op == esc_pkg::OP_DIV);
      last  = (pc_ff == esc_pkg::PC_W'(esc_pkg::PROG_LEN - 1));
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      unique case (state_ff)
         esc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = esc_pkg::ST_RUN;
               pc_in    = '0;
            end
         end
         esc_pkg::ST_RUN: begin
            if (!skip && multi) state_in = esc_pkg::ST_WAIT;
            else if (last) state_in = esc_pkg::ST_DONE;
            else pc_in = pc_ff + 1'b1;
         end
         esc_pkg::ST_WAIT: begin
            if (stat.unit_done) begin
               if (last) state_in = esc_pkg::ST_DONE;
               else begin
                  state_in = esc_pkg::ST_RUN;
                  pc_in    = pc_ff + 1'b1;
               end
            end
         end
         esc_pkg::ST_DONE: begin
            if (rsp_ready) state_in = esc_pkg::ST_IDLE;
         end
         default: state_in = esc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ctl.start = 1'b0;
      ctl.issue = 1'b0;
      ctl.cmd   = cmd;
      unique case (state_ff)
         esc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctl.start = req_valid;
         end
         esc_pkg::ST_RUN:  ctl.issue = !skip;
         esc_pkg::ST_WAIT: ;
         esc_pkg::ST_DONE: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= esc_pkg::ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end
endmodule

// ===== hdl/env_sensor_compensation.sv =====
// Environmental sensor compensation, top level.
// The microprogram runs 78 microsteps from input accept to result valid, of which 22 are
// multiplies and one the pressure divide, each waiting on the shared mul or the bit-serial
// divider; skipped channels shorten the run. One sample is taken at a time: a new one is
// accepted only after the receiver has taken the result of the last one.
// Synchronous active-high reset clears the calibration words, the fine temperature, the
// skip flags, the mul and div control and the controller; no clearing pass.
module env_sensor_compensation (
   input  logic        clock,
   input  logic        reset,
   esc_req_if.sink     req_ch,
   esc_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   esc_pkg::ctl_type  ctl;
   esc_pkg::stat_type stat;

   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   esc_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .raw_temp      (req_ch.raw_temp),
      .raw_press     (req_ch.raw_press),
      .raw_hum       (req_ch.raw_hum),
      .temperature   (rsp_ch.temperature),
      .pressure      (rsp_ch.pressure),
      .humidity      (rsp_ch.humidity),
      .temp_skipped  (rsp_ch.temp_skipped),
      .press_skipped (rsp_ch.press_skipped),
      .hum_skipped   (rsp_ch.hum_skipped)
   );
endmodule

// ===== hdl/esc_checker.sv =====
// Port-level checks for the compensation block, bound to the top level.
`include "env_sensor_compensation_defines.svh"

module esc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] temperature,
   input logic [16:0]        humidity,
   input logic               temp_skipped
);
   `ESC_ASSERT(a_one_at_a_time, clock, reset, !(req_ready && rsp_valid))
   `ESC_ASSERT(a_no_early_result, clock, reset, (req_valid && req_ready) |=> !rsp_valid)
   `ESC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid)
   `ESC_ASSERT(a_skip_zero, clock, reset,
      (rsp_valid && temp_skipped) |-> (temperature == 16'sd0))
   `ESC_ASSERT_ALWAYS(a_hum_range, clock, rsp_valid |-> (humidity <= 17'd102400))
endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .temperature  (rsp_ch.temperature),
   .humidity     (rsp_ch.humidity),
   .temp_skipped (rsp_ch.temp_skipped)
);

// ===== dv/env_sensor_compensation_test.sv =====
// Self-checking testbench for env_sensor_compensation: random and directed samples.
module env_sensor_compensation_test;

   typedef struct {
      logic signed [15:0] temperature;
      logic [31:0]        pressure;
      logic [16:0]        humidity;
      logic               temp_skipped;
      logic               press_skipped;
      logic               hum_skipped;
   } reading_type;

   class reading_board_type;
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      int     h1, h2, h3, h4, h5, h6;
      int     fine;
      reading_type pending[$];
      int     errors;
      int     checked;

      function void set_reg(esc_pkg::csr_index_type idx, logic [63:0] v);
         case (idx)
            esc_pkg::CSR_TEMP: begin
               t1 = longint'(v[15:0]);
               t2 = longint'($signed(v[31:16]));
               t3 = longint'($signed(v[47:32]));
            end
            esc_pkg::CSR_PRESS_LOW: begin
               p1 = longint'(v[15:0]);
               p2 = longint'($signed(v[31:16]));
               p3 = longint'($signed(v[47:32]));
               p4 = longint'($signed(v[63:48]));
            end
            esc_pkg::CSR_PRESS_HI: begin
               p5 = longint'($signed(v[15:0]));
               p6 = longint'($signed(v[31:16]));
               p7 = longint'($signed(v[47:32]));
               p8 = longint'($signed(v[63:48]));
            end
            esc_pkg::CSR_PRESS_P9: p9 = longint'($signed(v[15:0]));
            esc_pkg::CSR_HUM: begin
               h1 = int'(v[7:0]);
               h2 = int'($signed(v[23:8]));
               h3 = int'(v[31:24]);
               h4 = int'(v[43:32]);
               h5 = int'(v[55:44]);
               h6 = int'($signed(v[63:56]));
            end
            default: ;
         endcase
      endfunction

      function void note(logic [23:0] rt, logic [23:0] rp, logic [15:0] rh);
         reading_type r;
         longint adc, a, b, s, tq, d, v1, v2, p;
         int hv, x, y, z, w;
         r.temperature = 0;
         r.pressure = 0;
         r.humidity = 0;
         r.temp_skipped = (rt == esc_pkg::SKIP_CODE_24);
         r.press_skipped = (rp == esc_pkg::SKIP_CODE_24);
         r.hum_skipped = (rh == esc_pkg::SKIP_CODE_16);
         if (!r.temp_skipped) begin
            adc = longint'(rt >> 4);
            a = (adc >>> 3) - (t1 <<< 1);
            b = (adc >>> 4) - t1;
            s = ((a * t2) >>> 11) + ((((b * b) >>> 12) * t3) >>> 14);
            if (s > 64'sd2147483647) fine = 32'sh7FFFFFFF;
            else if (s < -64'sd2147483648) fine = 32'sh80000000;
            else fine = int'(s);
            tq = (longint'(fine) * 5 + 128) >>> 8;
            if (tq > 32767) tq = 32767;
            if (tq < -32768) tq = -32768;
            r.temperature = tq[15:0];
         end
         if (!r.press_skipped) begin
            adc = longint'(rp >> 4);
            d = longint'(fine) - 128000;
            v2 = d * d * p6 + ((d * p5) <<< 17) + (p4 <<< 35);
            v1 = ((d * d * p3) >>> 8) + ((d * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
            if (v1 == 0) begin
               r.press_skipped = 1'b1;
            end else begin
               p = 1048576 - adc;
               p = (((p <<< 31) - v2) * 3125) / v1;
               v1 = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
               v2 = (p8 * p) >>> 19;
               p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
               if (p < 0) r.pressure = 0;
               else if (p > 64'sh00000000FFFFFFFF) r.pressure = 32'hFFFFFFFF;
               else r.pressure = p[31:0];
            end
         end
         if (!r.hum_skipped) begin
            hv = fine - 76800;
            x = ((int'(rh) <<< 14) - (h4 <<< 20) - h5 * hv + 16384) >>> 15;
            y = (hv * h6) >>> 10;
            z = ((hv * h3) >>> 11) + 32768;
            w = ((y * z) >>> 10) + 2097152;
            w = (w * h2 + 8192) >>> 14;
            hv = x * w;
            y = hv >>> 15;
            hv = hv - ((((y * y) >>> 7) * h1) >>> 4);
            if (hv < 0) hv = 0;
            if (hv > 419430400) hv = 419430400;
            r.humidity = hv[28:12];
         end
         pending.push_back(r);
      endfunction

      task report(string s);
         $display("mismatch: %s", s);
         errors++;
      endtask

      task check(reading_type got);
         reading_type e;
         checked++;
         if (pending.size() == 0) begin
            report("result with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (got.temperature !== e.temperature)
            report($sformatf("temperature %0d, want %0d", got.temperature, e.temperature));
         if (got.pressure !== e.pressure)
            report($sformatf("pressure %h, want %h", got.pressure, e.pressure));
         if (got.humidity !== e.humidity)
            report($sformatf("humidity %h, want %h", got.humidity, e.humidity));
         if (got.temp_skipped !== e.temp_skipped)
            report($sformatf("temp_skipped %b, want %b", got.temp_skipped, e.temp_skipped));
         if (got.press_skipped !== e.press_skipped)
            report($sformatf("press_skipped %b, want %b", got.press_skipped,
                             e.press_skipped));
         if (got.hum_skipped !== e.hum_skipped)
            report($sformatf("hum_skipped %b, want %b", got.hum_skipped, e.hum_skipped));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   esc_req_if req ();
   esc_rsp_if rsp ();

   env_sensor_compensation u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req),
      .rsp_ch    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   reading_board_type board = new();
   bit  calm;
   int  rx_hold;
   int  sent;
   int  configs;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("status: fail");
      $finish;
   end

   task automatic send_sample(logic [23:0] rt, logic [23:0] rp, logic [15:0] rh);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.raw_temp  <= rt;
      req.raw_press <= rp;
      req.raw_hum   <= rh;
      do @(posedge clock); while (!req.ready);
      board.note(rt, rp, rh);
      sent++;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic load_cal(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
                           logic [63:0] p9, logic [63:0] hc);
      logic [63:0] vals [5];
      esc_pkg::csr_index_type idx;
      vals = '{tc, pl, ph, p9, hc};
      drain();
      repeat (20) @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         idx = esc_pkg::csr_index_type'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         @(posedge clock);
         board.set_reg(idx, vals[i]);
      end
      csr_we <= 1'b0;
      configs++;
   endtask

   function automatic logic [23:0] pick24(int lo, int hi);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return esc_pkg::SKIP_CODE_24;
      if (r < 4) return 24'($urandom);
      if (r == 4) return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
      return 24'($urandom_range(hi, lo));
   endfunction

   function automatic logic [15:0] pick16();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return esc_pkg::SKIP_CODE_16;
      if (r < 4) return 16'($urandom);
      if (r == 4) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      return 16'($urandom_range(16'hA000, 16'h3000));
   endfunction

   task automatic random_run(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         send_sample(pick24(24'h6A0000, 24'h900000), pick24(24'h3C0000, 24'h700000),
                     pick16());
      end
      calm = 1'b0;
   endtask

   // receiver
   initial begin
      reading_type got;
      int stall;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 11);
         if (rx_hold > 0) begin
            stall = rx_hold;
            rx_hold = 0;
         end
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         got.temperature   = rsp.temperature;
         got.pressure      = rsp.pressure;
         got.humidity      = rsp.humidity;
         got.temp_skipped  = rsp.temp_skipped;
         got.press_skipped = rsp.press_skipped;
         got.hum_skipped   = rsp.hum_skipped;
         board.check(got);
      end
   end

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = esc_pkg::CSR_TEMP;
      csr_wdata     = '0;
      req.valid     = 1'b0;
      req.raw_temp  = '0;
      req.raw_press = '0;
      req.raw_hum   = '0;
      calm = 1'b0;
      rx_hold = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: pressure divisor is zero
      send_sample(24'h800000, 24'h5A0000, 16'h6000);

      // typical sensor calibration
      load_cal(64'({16'hFC18, 16'h6743, 16'h6B70}),
               {16'h0B27, 16'h0BD0, 16'hD643, 16'h8E7D},
               {16'hC6F8, 16'h3C8C, 16'hFFF9, 16'h008C},
               64'h1770,
               {8'h1E, 12'h032, 12'h139, 8'h00, 16'h016A, 8'h4B});
      send_sample(24'h800000, 24'h800000, 16'h8000);
      send_sample(24'h7E0000, 24'h5A0000, 16'h6000);
      send_sample(24'h000000, 24'h000000, 16'h0000);
      send_sample(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
      send_sample(24'h800000, 24'h5A0000, 16'h6000);
      send_sample(24'h7FFFFF, 24'h800001, 16'h7FFF);
      send_sample(24'h800001, 24'h7FFFFF, 16'h8001);
      send_sample(24'h7F0000, 24'h800000, 16'h8000);
      send_sample(24'h800000, 24'h000000, 16'hFFFF);
      send_sample(24'h555555, 24'hAAAAAA, 16'h5555);
      send_sample(24'hAAAAAA, 24'h555555, 16'hAAAA);
      random_run(40);

      // long receiver stall while the sender keeps offering samples
      drain();
      calm = 1'b1;
      rx_hold = 3000;
      random_run(12);
      drain();
      repeat (50) @(posedge clock);
      random_run(250);

      load_cal('0, '0, '0, '0, '0);
      random_run(50);
      load_cal('1, '1, '1, '1, '1);
      random_run(60);
      load_cal(64'({16'h7FFF, 16'h7FFF, 16'h0000}),
               {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
               {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
               64'h7FFF,
               {8'h7F, 12'hFFF, 12'hFFF, 8'hFF, 16'h7FFF, 8'hFF});
      random_run(60);
      load_cal(64'({16'h8000, 16'h8000, 16'hFFFF}),
               {16'h8000, 16'h8000, 16'h8000, 16'h0001},
               {16'h8000, 16'h8000, 16'h8000, 16'h8000},
               64'h8000,
               {8'h80, 12'h000, 12'h000, 8'h00, 16'h8000, 8'h00});
      random_run(60);
      for (int k = 0; k < 6; k++) begin
         load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
         random_run(70);
      end

      drain();
      repeat (400) @(posedge clock);
      $display("run: %0d samples over %0d calibration sets, %0d results checked",
               sent, configs, board.checked);
      $display("covered skip codes, zero divisor, saturation and long output stalls");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ===== env_sensor_compensation.f =====
+incdir+hdl
hdl/esc_pkg.sv
hdl/esc_if.sv
hdl/esc_mul.sv
hdl/esc_div.sv
hdl/esc_datapath.sv
hdl/esc_ctrl.sv
hdl/env_sensor_compensation.sv
hdl/esc_checker.sv
dv/env_sensor_compensation_test.sv
